/* rtl/slabclip_pkg.sv */
// ----------------------------------------------------------------------------
// slabclip_pkg
// Shared codes and the controller/datapath interface types for the slab
// polyline clipper.
// ----------------------------------------------------------------------------
package slabclip_pkg;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_RING  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [2:0] SRC_CUR    = 3'd0;
    localparam logic [2:0] SRC_PREV   = 3'd1;
    localparam logic [2:0] SRC_CROSS  = 3'd2;
    localparam logic [2:0] SRC_SFIRST = 3'd3;
    localparam logic [2:0] SRC_SLAST  = 3'd4;

    localparam logic [1:0] DIVM_LOW   = 2'd0;
    localparam logic [1:0] DIVM_HIGH  = 2'd1;
    localparam logic [1:0] DIVM_CROSS = 2'd2;

    localparam logic [1:0] REG_LOW    = 2'd0;
    localparam logic [1:0] REG_HIGH   = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;
    localparam logic [1:0] REG_AXIS   = 2'd3;

    localparam int EDGE_W  = 32;
    localparam int SCALE_W = 25;

    typedef struct packed {
        logic       latch;
        logic       div_start;
        logic       div_store;
        logic [1:0] div_mode;
        logic       xprep;
        logic       edge_hi;
        logic       xmul;
        logic       emit;
        logic [2:0] src;
        logic       clear_open;
        logic       end_slice;
        logic       prev_upd;
        logic       flush;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       first;
        logic       last;
        logic       ak_lt;
        logic       ak_gt;
        logic       bk_lt;
        logic       bk_gt;
        logic       slice_open;
        logic       ends_differ;
        logic       pend_v;
        logic       can_emit;
        logic       can_flush;
        logic       div_busy;
        logic       den_zero;
    } t_sts;

endpackage

/* rtl/slabclip_div.sv */
// ----------------------------------------------------------------------------
// slabclip_div
// Serial restoring divider, BPC quotient bits per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module slabclip_div #(
    parameter int NW  = 64,
    parameter int DVW = 32,
    parameter int BPC = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_busy,
    output logic [NW-1:0]  o_quotient
);

    localparam int ITER = (NW + BPC - 1) / BPC;
    localparam int PW   = ITER * BPC;
    localparam int CNTW = $clog2(ITER + 1);

    logic [PW-1:0]   r_q;
    logic [PW-1:0]   n_q;
    logic [DVW-1:0]  r_rem;
    logic [DVW-1:0]  n_rem;
    logic [DVW-1:0]  r_d;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;

    always_comb begin
        logic [DVW:0] t;
        n_q   = r_q;
        n_rem = r_rem;
        for (int j = 0; j < BPC; j++) begin
            t   = {n_rem, n_q[PW-1]};
            n_q = {n_q[PW-2:0], 1'b0};
            if (t >= {1'b0, r_d}) begin
                t      = t - {1'b0, r_d};
                n_q[0] = 1'b1;
            end
            n_rem = t[DVW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTW'(ITER);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= PW'(i_dividend);
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q[NW-1:0];

endmodule

/* rtl/slabclip_ctrl.sv */
// ----------------------------------------------------------------------------
// slabclip_ctrl
// Sequencer: edge scaling, segment steps, ring closing and result flush.
// ----------------------------------------------------------------------------
module slabclip_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  slabclip_pkg::t_sts  i_sts,
    output slabclip_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DWAIT  = 3'd3;
    localparam logic [2:0] S_STEP   = 3'd4;
    localparam logic [2:0] S_XPREP  = 3'd5;
    localparam logic [2:0] S_XMUL   = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    localparam logic [2:0] ST_OP0 = 3'd0;
    localparam logic [2:0] ST_OP1 = 3'd1;
    localparam logic [2:0] ST_SEG = 3'd2;
    localparam logic [2:0] ST_L0  = 3'd3;
    localparam logic [2:0] ST_L1  = 3'd4;
    localparam logic [2:0] ST_L2  = 3'd5;
    localparam logic [2:0] ST_FIN = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_mode, n_mode;
    logic [2:0] r_src, n_src;
    logic       r_edge_hi, n_edge_hi;

    always_comb begin
        logic       is_point;
        logic       closed;
        logic       in_band;
        logic       seg_end;
        logic       act_emit;
        logic       act_cross;
        logic       a_hi;
        logic [2:0] a_src;
        logic [2:0] nxt;
        is_point  = (i_sts.kind == slabclip_pkg::KIND_POINT);
        closed    = (i_sts.kind == slabclip_pkg::KIND_RING);
        in_band   = !i_sts.bk_lt && !i_sts.bk_gt;
        seg_end   = (i_sts.ak_lt && i_sts.bk_gt)
                 || (!i_sts.ak_lt && i_sts.ak_gt && i_sts.bk_lt)
                 || (!i_sts.ak_lt && !i_sts.ak_gt && (i_sts.bk_lt || i_sts.bk_gt));
        act_emit  = 1'b0;
        act_cross = 1'b0;
        a_hi      = 1'b0;
        a_src     = slabclip_pkg::SRC_CUR;
        nxt       = r_step;
        n_state   = r_state;
        n_step    = r_step;
        n_mode    = r_mode;
        n_src     = r_src;
        n_edge_hi = r_edge_hi;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.kind == slabclip_pkg::KIND_NONE) begin
                    n_state = S_IDLE;
                end else if (is_point || i_sts.first) begin
                    n_mode  = slabclip_pkg::DIVM_LOW;
                    n_state = S_DSTART;
                end else begin
                    n_step  = ST_OP0;
                    n_state = S_STEP;
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_mode  = r_mode;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_store = 1'b1;
                    o_cmd.div_mode  = r_mode;
                    case (r_mode)
                        slabclip_pkg::DIVM_LOW: begin
                            n_mode  = slabclip_pkg::DIVM_HIGH;
                            n_state = S_DSTART;
                        end
                        slabclip_pkg::DIVM_HIGH: begin
                            n_step  = ST_OP0;
                            n_state = S_STEP;
                        end
                        default: begin
                            n_src   = slabclip_pkg::SRC_CROSS;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_XPREP: begin
                o_cmd.xprep   = 1'b1;
                o_cmd.edge_hi = r_edge_hi;
                n_state       = S_XMUL;
            end
            S_XMUL: begin
                o_cmd.xmul = 1'b1;
                if (i_sts.den_zero) begin
                    n_src   = slabclip_pkg::SRC_CROSS;
                    n_state = S_EMIT;
                end else begin
                    n_mode  = slabclip_pkg::DIVM_CROSS;
                    n_state = S_DSTART;
                end
            end
            S_EMIT: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = r_src;
                    n_state    = S_STEP;
                end
            end
            S_STEP: begin
                case (r_step)
                    ST_OP0: begin
                        if (is_point) begin
                            act_emit = in_band;
                            nxt      = ST_FIN;
                        end else if (i_sts.first) begin
                            nxt = ST_SEG;
                        end else begin
                            nxt = ST_OP1;
                            if (i_sts.ak_lt) begin
                                act_cross = i_sts.bk_gt || !i_sts.bk_lt;
                            end else if (i_sts.ak_gt) begin
                                act_cross = i_sts.bk_lt || !i_sts.bk_gt;
                                a_hi      = 1'b1;
                            end else begin
                                act_emit = 1'b1;
                                a_src    = slabclip_pkg::SRC_PREV;
                            end
                        end
                    end
                    ST_OP1: begin
                        nxt = ST_SEG;
                        if (i_sts.ak_lt) begin
                            act_cross = i_sts.bk_gt;
                            a_hi      = 1'b1;
                        end else if (i_sts.ak_gt) begin
                            act_cross = i_sts.bk_lt;
                        end else begin
                            act_cross = i_sts.bk_lt || i_sts.bk_gt;
                            a_hi      = !i_sts.bk_lt;
                        end
                    end
                    ST_SEG: begin
                        o_cmd.prev_upd   = 1'b1;
                        o_cmd.clear_open = i_sts.first;
                        o_cmd.end_slice  = !i_sts.first && !closed && seg_end;
                        nxt              = i_sts.last ? ST_L0 : ST_FIN;
                    end
                    ST_L0: begin
                        act_emit = in_band;
                        nxt      = ST_L1;
                    end
                    ST_L1: begin
                        act_emit = closed && i_sts.slice_open && i_sts.ends_differ;
                        a_src    = slabclip_pkg::SRC_SFIRST;
                        nxt      = ST_L2;
                    end
                    ST_L2: begin
                        act_emit = i_sts.slice_open && !i_sts.pend_v;
                        a_src    = slabclip_pkg::SRC_SLAST;
                        nxt      = ST_FIN;
                    end
                    ST_FIN: begin
                        if (i_sts.can_flush || !i_sts.pend_v) begin
                            o_cmd.end_slice = !is_point && i_sts.last;
                            o_cmd.flush     = 1'b1;
                            n_state         = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
                if (r_step != ST_FIN) begin
                    n_step = nxt;
                    if (act_cross) begin
                        n_edge_hi = a_hi;
                        n_state   = S_XPREP;
                    end else if (act_emit) begin
                        n_src   = a_src;
                        n_state = S_EMIT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= ST_OP0;
            r_mode    <= slabclip_pkg::DIVM_LOW;
            r_src     <= slabclip_pkg::SRC_CUR;
            r_edge_hi <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_mode    <= n_mode;
            r_src     <= n_src;
            r_edge_hi <= n_edge_hi;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* rtl/slabclip_dp.sv */
// ----------------------------------------------------------------------------
// slabclip_dp
// Datapath: vertex and slice state, scaled edges, crossing arithmetic with
// the shared serial divider, pending result and output register.
// ----------------------------------------------------------------------------
module slabclip_dp #(
    parameter int CW  = 32,
    parameter int BPC = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  slabclip_pkg::t_cmd                  i_cmd,
    output slabclip_pkg::t_sts                  o_sts,
    input  logic [1:0]                          i_kind,
    input  logic signed [CW-1:0]                i_x,
    input  logic signed [CW-1:0]                i_y,
    input  logic                                i_first,
    input  logic                                i_last,
    input  logic signed [slabclip_pkg::EDGE_W-1:0] i_low_edge,
    input  logic signed [slabclip_pkg::EDGE_W-1:0] i_high_edge,
    input  logic [slabclip_pkg::SCALE_W-1:0]    i_scale,
    input  logic                                i_axis,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [CW-1:0]                o_out_x,
    output logic signed [CW-1:0]                o_out_y,
    output logic                                o_out_end,
    output logic                                o_out_last
);

    localparam int EW = (CW > slabclip_pkg::EDGE_W) ? CW : slabclip_pkg::EDGE_W;
    localparam int DW = EW + 1;
    localparam int NW = 2 * EW;
    localparam int SW = NW + 2;
    localparam logic [NW-1:0] QLIM = NW'(1) << 40;
    localparam logic signed [SW-1:0] C_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] C_MIN = ~C_MAX;

    logic [1:0]           r_kind;
    logic signed [CW-1:0] r_cx, r_cy;
    logic                 r_first, r_last;
    logic signed [CW-1:0] r_prev_x, r_prev_y;
    logic signed [CW-1:0] r_sf_x, r_sf_y, r_sl_x, r_sl_y;
    logic                 r_open;
    logic signed [slabclip_pkg::EDGE_W-1:0] r_scaled_low, r_scaled_high;
    logic [EW-1:0]        r_mnum, r_mden, r_mspan;
    logic                 r_neg, r_den_zero;
    logic signed [CW-1:0] r_oa;
    logic signed [EW-1:0] r_xe;
    logic [NW-1:0]        r_prod;
    logic signed [CW-1:0] r_cross_o;
    logic                 r_pend_v, r_pend_end;
    logic signed [CW-1:0] r_pend_x, r_pend_y;
    logic                 r_out_v, r_out_end, r_out_last;
    logic signed [CW-1:0] r_out_x, r_out_y;

    logic signed [EW-1:0] w_k1, w_k2, w_ak, w_bk, w_ka, w_oa, w_kb, w_ob, w_e;
    logic signed [DW-1:0] w_num, w_den, w_span;
    logic [EW-1:0]        w_anum, w_aden, w_aspan;
    logic signed [slabclip_pkg::EDGE_W:0] w_edge, w_eabs;
    logic [slabclip_pkg::SCALE_W-1:0]     w_scale_nz;
    logic [NW-1:0]        w_dividend;
    logic [EW-1:0]        w_divisor;
    logic                 w_div_busy;
    logic [NW-1:0]        w_quo;
    logic [NW-1:0]        w_qcl;
    logic signed [SW-1:0] w_qext, w_sum;
    logic signed [CW-1:0] w_sat;
    logic [slabclip_pkg::EDGE_W-1:0] w_q32, w_scaled;
    logic signed [CW-1:0] w_pt_x, w_pt_y, w_xe_c;
    logic                 w_track, w_can_emit, w_can_flush, w_end_now;

    assign w_k1 = EW'(r_scaled_low);
    assign w_k2 = EW'(r_scaled_high);
    assign w_ak = i_axis ? EW'(r_prev_y) : EW'(r_prev_x);
    assign w_bk = i_axis ? EW'(r_cy) : EW'(r_cx);
    assign w_ka = w_ak;
    assign w_oa = i_axis ? EW'(r_prev_x) : EW'(r_prev_y);
    assign w_kb = w_bk;
    assign w_ob = i_axis ? EW'(r_cx) : EW'(r_cy);
    assign w_e  = i_cmd.edge_hi ? w_k2 : w_k1;

    assign w_num   = DW'(w_e) - DW'(w_ka);
    assign w_den   = DW'(w_kb) - DW'(w_ka);
    assign w_span  = DW'(w_ob) - DW'(w_oa);
    assign w_anum  = w_num[DW-1]  ? EW'(-w_num)  : EW'(w_num);
    assign w_aden  = w_den[DW-1]  ? EW'(-w_den)  : EW'(w_den);
    assign w_aspan = w_span[DW-1] ? EW'(-w_span) : EW'(w_span);

    assign w_edge     = (i_cmd.div_mode == slabclip_pkg::DIVM_HIGH) ?
                        (slabclip_pkg::EDGE_W+1)'(i_high_edge) :
                        (slabclip_pkg::EDGE_W+1)'(i_low_edge);
    assign w_eabs     = w_edge[slabclip_pkg::EDGE_W] ? -w_edge : w_edge;
    assign w_scale_nz = (i_scale == '0) ? slabclip_pkg::SCALE_W'(1) : i_scale;

    always_comb begin
        if (i_cmd.div_mode == slabclip_pkg::DIVM_CROSS) begin
            w_dividend = r_prod;
            w_divisor  = r_mden;
        end else begin
            w_dividend = NW'(w_eabs[slabclip_pkg::EDGE_W-1:0]);
            w_divisor  = EW'(w_scale_nz);
        end
    end

    slabclip_div #(
        .NW  (NW),
        .DVW (EW),
        .BPC (BPC)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign w_q32    = w_quo[slabclip_pkg::EDGE_W-1:0];
    assign w_scaled = w_edge[slabclip_pkg::EDGE_W] ? -w_q32 : w_q32;

    assign w_qcl  = (w_quo > QLIM) ? QLIM : w_quo;
    assign w_qext = {2'b00, w_qcl};
    assign w_sum  = r_neg ? (SW'(r_oa) - w_qext) : (SW'(r_oa) + w_qext);
    always_comb begin
        if (w_sum > C_MAX) begin
            w_sat = C_MAX[CW-1:0];
        end else if (w_sum < C_MIN) begin
            w_sat = C_MIN[CW-1:0];
        end else begin
            w_sat = w_sum[CW-1:0];
        end
    end

    assign w_xe_c = r_xe[CW-1:0];
    always_comb begin
        case (i_cmd.src)
            slabclip_pkg::SRC_PREV: begin
                w_pt_x = r_prev_x;
                w_pt_y = r_prev_y;
            end
            slabclip_pkg::SRC_CROSS: begin
                w_pt_x = i_axis ? r_cross_o : w_xe_c;
                w_pt_y = i_axis ? w_xe_c : r_cross_o;
            end
            slabclip_pkg::SRC_SFIRST: begin
                w_pt_x = r_sf_x;
                w_pt_y = r_sf_y;
            end
            slabclip_pkg::SRC_SLAST: begin
                w_pt_x = r_sl_x;
                w_pt_y = r_sl_y;
            end
            default: begin
                w_pt_x = r_cx;
                w_pt_y = r_cy;
            end
        endcase
    end

    assign w_track     = (r_kind != slabclip_pkg::KIND_POINT);
    assign w_can_flush = !r_out_v || i_out_ready;
    assign w_can_emit  = !r_pend_v || w_can_flush;
    assign w_end_now   = i_cmd.end_slice && r_open && r_pend_v;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind  <= i_kind;
            r_cx    <= i_x;
            r_cy    <= i_y;
            r_first <= i_first;
            r_last  <= i_last;
        end
        if (i_cmd.xprep) begin
            r_mnum     <= w_anum;
            r_mden     <= w_aden;
            r_mspan    <= w_aspan;
            r_neg      <= (w_num[DW-1] ^ w_den[DW-1]) ^ w_span[DW-1];
            r_den_zero <= (w_den == '0);
            r_oa       <= w_oa[CW-1:0];
            r_xe       <= w_e;
        end
        if (i_cmd.xmul) begin
            r_prod <= NW'(r_mnum) * NW'(r_mspan);
            if (r_den_zero) begin
                r_cross_o <= r_oa;
            end
        end
        if (i_cmd.div_store && (i_cmd.div_mode == slabclip_pkg::DIVM_CROSS)) begin
            r_cross_o <= w_sat;
        end
        if (i_cmd.emit) begin
            r_pend_x <= w_pt_x;
            r_pend_y <= w_pt_y;
        end
        if ((i_cmd.emit || i_cmd.flush) && r_pend_v) begin
            r_out_x    <= r_pend_x;
            r_out_y    <= r_pend_y;
            r_out_end  <= r_pend_end || (i_cmd.flush && w_end_now);
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x      <= '0;
            r_prev_y      <= '0;
            r_sf_x        <= '0;
            r_sf_y        <= '0;
            r_sl_x        <= '0;
            r_sl_y        <= '0;
            r_open        <= 1'b0;
            r_scaled_low  <= '0;
            r_scaled_high <= '0;
            r_pend_v      <= 1'b0;
            r_pend_end    <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if ((i_cmd.emit || i_cmd.flush) && r_pend_v) begin
                r_out_v <= 1'b1;
            end
            if (i_cmd.div_store && (i_cmd.div_mode == slabclip_pkg::DIVM_LOW)) begin
                r_scaled_low <= w_scaled;
            end
            if (i_cmd.div_store && (i_cmd.div_mode == slabclip_pkg::DIVM_HIGH)) begin
                r_scaled_high <= w_scaled;
            end
            if (i_cmd.prev_upd) begin
                r_prev_x <= r_cx;
                r_prev_y <= r_cy;
            end
            if (i_cmd.clear_open || i_cmd.end_slice) begin
                r_open <= 1'b0;
            end
            if (w_end_now) begin
                r_pend_end <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_pend_v   <= 1'b1;
                r_pend_end <= 1'b0;
                if (w_track) begin
                    if (!r_open) begin
                        r_sf_x <= w_pt_x;
                        r_sf_y <= w_pt_y;
                        r_open <= 1'b1;
                    end
                    r_sl_x <= w_pt_x;
                    r_sl_y <= w_pt_y;
                end
            end
            if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.kind        = r_kind;
        o_sts.first       = r_first;
        o_sts.last        = r_last;
        o_sts.ak_lt       = (w_ak < w_k1);
        o_sts.ak_gt       = (w_ak > w_k2);
        o_sts.bk_lt       = (w_bk < w_k1);
        o_sts.bk_gt       = (w_bk > w_k2);
        o_sts.slice_open  = r_open;
        o_sts.ends_differ = (r_sf_x != r_sl_x) || (r_sf_y != r_sl_y);
        o_sts.pend_v      = r_pend_v;
        o_sts.can_emit    = w_can_emit;
        o_sts.can_flush   = w_can_flush;
        o_sts.div_busy    = w_div_busy;
        o_sts.den_zero    = r_den_zero;
    end

    assign o_out_valid = r_out_v;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_end   = r_out_end;
    assign o_out_last  = r_out_last;

endmodule

/* rtl/axis_slab_polyline_clipper_core.sv */
// ----------------------------------------------------------------------------
// axis_slab_polyline_clipper_core
// Clips points, open lines and polygon rings against a slab on one axis.
//
//  channel  direction  handshake              payload
//  s_*      in         s_tvalid / s_tready    tdata x,y,first; tuser kind; tlast
//  m_*      out        m_tvalid / m_tready    tdata x,y; tuser slice end; tlast
//  apb      in         psel/penable, pready=1 edge, scale, axis registers
//
// One item at a time. Edge scaling (points, first vertices) runs two serial
// divisions of 2*EW/DIV_BITS_PER_CYCLE steps each (64 at defaults). Each
// crossing costs one multiply and one such division; a vertex has at most
// two crossings.
// Reset is synchronous; no clearing pass. A stalled m_tready holds the
// output register and, once the pending result is also full, the sequencer.
// ----------------------------------------------------------------------------
module axis_slab_polyline_clipper_core #(
    parameter int COORD_WIDTH        = 32,
    parameter int DIV_BITS_PER_CYCLE = 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // coord_x, coord_y, ring_first, zero pad
    input  logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic [1:0] s_tuser,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // out_x, out_y, zero pad
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // slice_end
    output logic [0:0] m_tuser,
    output logic m_tlast,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);

    localparam int CW  = COORD_WIDTH;
    localparam int ODW = ((2*CW+7)/8)*8;

    logic signed [slabclip_pkg::EDGE_W-1:0] r_low_edge, r_high_edge;
    logic [slabclip_pkg::SCALE_W-1:0]       r_scale;
    logic                                   r_axis;
    logic                                   w_wr;
    slabclip_pkg::t_cmd                     w_cmd;
    slabclip_pkg::t_sts                     w_sts;
    logic signed [CW-1:0]                   w_out_x, w_out_y;
    logic                                   w_out_end;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_edge  <= '0;
            r_high_edge <= 32'sd1073741824;
            r_scale     <= slabclip_pkg::SCALE_W'(1);
            r_axis      <= 1'b0;
        end else if (w_wr) begin
            case (paddr[3:2])
                slabclip_pkg::REG_LOW:   r_low_edge  <= pwdata;
                slabclip_pkg::REG_HIGH:  r_high_edge <= pwdata;
                slabclip_pkg::REG_SCALE: r_scale     <= pwdata[slabclip_pkg::SCALE_W-1:0];
                slabclip_pkg::REG_AXIS:  r_axis      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            slabclip_pkg::REG_LOW:   prdata = r_low_edge;
            slabclip_pkg::REG_HIGH:  prdata = r_high_edge;
            slabclip_pkg::REG_SCALE: prdata = 32'(r_scale);
            slabclip_pkg::REG_AXIS:  prdata = 32'(r_axis);
            default:                 prdata = '0;
        endcase
    end

    slabclip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    slabclip_dp #(
        .CW  (CW),
        .BPC (DIV_BITS_PER_CYCLE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_kind      (s_tuser),
        .i_x         (s_tdata[CW-1:0]),
        .i_y         (s_tdata[2*CW-1:CW]),
        .i_first     (s_tdata[2*CW]),
        .i_last      (s_tlast),
        .i_low_edge  (r_low_edge),
        .i_high_edge (r_high_edge),
        .i_scale     (r_scale),
        .i_axis      (r_axis),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_out_x     (w_out_x),
        .o_out_y     (w_out_y),
        .o_out_end   (w_out_end),
        .o_out_last  (m_tlast)
    );

    assign m_tdata    = ODW'({w_out_y, w_out_x});
    assign m_tuser[0] = w_out_end;

endmodule

/* rtl/slabclip_chk.sv */
// ----------------------------------------------------------------------------
// slabclip_chk
// Port-level checks for the slab clipper core, bound to the top level.
// ----------------------------------------------------------------------------
module slabclip_chk #(
    parameter int ODW = 64
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [ODW-1:0] m_tdata,
    input logic           m_tlast,
    input logic           pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind axis_slab_polyline_clipper_core slabclip_chk #(
    .ODW (((2*COORD_WIDTH+7)/8)*8)
) u_slabclip_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
